// ===== hw/rtl/sd2_pkg.sv =====
// ============================================================================
// sd2_pkg: shared types and constants of the 2D smooth-damp block
// Carries the request and result payload structs and the register indexes.
// ============================================================================
package sd2_pkg;

  typedef struct packed {
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic        [30:0] delta_time;
  } sd2_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               snapped;
  } sd2_out_t;

  localparam logic [0:0] REG_SMOOTH_TIME = 1'b0;
  localparam logic [0:0] REG_MAX_SPEED   = 1'b1;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_NOP
  } sd2_op_t;

  typedef struct packed {
    logic    start;
    sd2_op_t op;
    logic [5:0] step;
  } sd2_cmd_t;

  typedef struct packed {
    logic done;
  } sd2_stat_t;

endpackage

// ===== hw/rtl/sd2_ctrl.sv =====
// ============================================================================
// sd2_ctrl: step sequencer of the 2D smooth-damp block
// Walks the datapath through the micro-steps of one request.
// ============================================================================
module sd2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  sd2_pkg::sd2_stat_t stat,
  output sd2_pkg::sd2_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import sd2_pkg::*;

  localparam logic [5:0] LastStep = 6'd35;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

  state_t     state_r;
  logic [5:0] step_r;
  logic       start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            step_r  <= '0;
            start_r <= 1'b1;
            state_r <= S_WAIT;
          end
        end
        S_ISSUE: begin
          start_r <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (stat.done && !start_r) begin
            if (step_r == LastStep) begin
              state_r <= S_OUT;
            end else begin
              step_r  <= step_r + 6'd1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (out_fire) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd.start  = start_r;
  assign cmd.op     = OP_NOP;
  assign cmd.step   = step_r;
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without request");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LastStep) else $error("step overrun");
  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> !start_r) else $error("start held");
endmodule

// ===== hw/rtl/sd2_datapath.sv =====
// ============================================================================
// sd2_datapath: arithmetic of the 2D smooth-damp block
// Holds the working registers, one shared multiplier, and an iterative
// divider and square-root unit; each micro-step does one operation.
// ============================================================================
module sd2_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  sd2_pkg::sd2_in_t   in_data,
  input  logic               cfg_fire,
  input  logic [0:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata,
  input  logic               cfg_hit,
  input  sd2_pkg::sd2_cmd_t  cmd,
  output sd2_pkg::sd2_stat_t stat,
  output sd2_pkg::sd2_out_t  res
);
  import sd2_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 2;
  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};
  localparam longint OneQ = longint'(1) << F;
  localparam longint StMinR = (OneQ + 5000) / 10000;
  localparam longint StMin = (StMinR < 1) ? 1 : StMinR;
  localparam longint C48 = (48 * OneQ + 50) / 100;
  localparam longint C235 = (235 * OneQ + 500) / 1000;
  localparam int CW = $clog2(PW + 1);

  // Working registers.
  logic signed [W-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r, dt_r;
  logic signed [W-1:0] st_r, ms_r, omega_r, x_r, xx_r, xxx_r, den_r, dec_r;
  logic signed [W-1:0] cx_r, cy_r, lim_r, tx_r, ty_r, vx_r, vy_r, ox_r, oy_r;
  logic signed [W-1:0] vel_x_r, vel_y_r, t_r;
  logic [PW-1:0]       sq_r, lsq_r, len_r, pos_r, neg_r;
  logic                snap_r, clamp_r;
  logic [30:0]         smooth_time_r, max_speed_r;

  // Shared multiplier: exact product of magnitudes, one per micro-step.
  logic signed [W-1:0] ma, mb;
  logic [W-1:0]        mam, mbm;
  logic [2*W-1:0]      mprod;
  logic                mneg;

  function automatic logic signed [W-1:0] satf(input logic signed [W+1:0] v);
    if (v > $signed({{2{1'b0}}, WMax})) return WMax;
    if (v < $signed({{2{1'b1}}, WMin})) return WMin;
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] magf(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic [W-1:0] magw(input logic signed [W:0] v);
    return v[W] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] smag(input logic neg,
                                               input logic [PW-1:0] m);
    if (m > PW'(WMax)) return neg ? WMin : WMax;
    return neg ? W'(-$signed(m[W-1:0])) : W'(m[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] add(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    return satf((W+2)'(a) + (W+2)'(b));
  endfunction

  function automatic logic signed [W-1:0] sub(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    return satf((W+2)'(a) - (W+2)'(b));
  endfunction

  function automatic logic signed [W-1:0] sat32w(input logic signed [W-1:0] v);
    logic signed [W+1:0] e;
    e = (W+2)'(v);
    if (e > (W+2)'(64'sd2147483647)) return W'(64'sd2147483647);
    if (e < (W+2)'(-64'sd2147483648)) return W'(-64'sd2147483648);
    return v;
  endfunction

  logic [2*W-1:0] mprod_r;
  logic           mneg_r;
  always_ff @(posedge clk) begin
    mprod_r <= mam * mbm;
    mneg_r  <= mneg;
  end
  assign mprod = mprod_r;

  logic signed [W-1:0] mulq;
  assign mulq = smag(mneg_r, PW'(mprod >> F));

  // Iterative divider / square root.
  logic [PW-1:0] dn_r, dd_r, dq_r, drem_r;
  logic [CW-1:0] dcnt_r;
  logic          dbusy_r, dsqrt_r;
  logic [PW:0]   dtrial;
  logic [PW-1:0] srem, sroot;

  assign dtrial = {drem_r, dn_r[PW-1]} - {1'b0, dd_r};
  assign srem   = {drem_r[PW-3:0], dn_r[PW-1:PW-2]};
  assign sroot  = {dq_r[PW-3:0], 2'b01};

  // Micro-step sequence.
  logic [5:0] step;
  logic       mphase_r;
  logic       done;

  assign step = cmd.step;

  // The overshoot test multiplies exact differences, one bit wider than a word.
  logic signed [W:0] da, db;
  logic              dot_step;

  assign dot_step = (step == 6'd26) || (step == 6'd27);

  always_comb begin
    da = '0;
    db = '0;
    case (step)
      6'd26: begin
        da = (W+1)'(tgt_x_r) - (W+1)'(cur_x_r);
        db = (W+1)'(ox_r) - (W+1)'(tgt_x_r);
      end
      6'd27: begin
        da = (W+1)'(tgt_y_r) - (W+1)'(cur_y_r);
        db = (W+1)'(oy_r) - (W+1)'(tgt_y_r);
      end
      default: begin da = '0; db = '0; end
    endcase
  end

  assign mam  = dot_step ? magw(da) : magf(ma);
  assign mbm  = dot_step ? magw(db) : magf(mb);
  assign mneg = dot_step ? (da[W] ^ db[W]) : (ma[W-1] ^ mb[W-1]);

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      6'd1:  begin ma = omega_r; mb = dt_r; end
      6'd2:  begin ma = x_r; mb = x_r; end
      6'd3:  begin ma = xx_r; mb = x_r; end
      6'd4:  begin ma = W'(C48); mb = xx_r; end
      6'd5:  begin ma = W'(C235); mb = xxx_r; end
      6'd7:  begin ma = ms_r; mb = st_r; end
      6'd8:  begin ma = cx_r; mb = cx_r; end
      6'd9:  begin ma = cy_r; mb = cy_r; end
      6'd10: begin ma = lim_r; mb = lim_r; end
      6'd12: begin ma = W'(magf(cx_r)); mb = lim_r; end
      6'd14: begin ma = W'(magf(cy_r)); mb = lim_r; end
      6'd16: begin ma = cx_r; mb = omega_r; end
      6'd17: begin ma = add(vx_r, t_r); mb = dt_r; end
      6'd18: begin ma = cy_r; mb = omega_r; end
      6'd19: begin ma = add(vy_r, t_r); mb = dt_r; end
      6'd20: begin ma = tx_r; mb = omega_r; end
      6'd21: begin ma = sub(vx_r, t_r); mb = dec_r; end
      6'd22: begin ma = ty_r; mb = omega_r; end
      6'd23: begin ma = sub(vy_r, t_r); mb = dec_r; end
      6'd24: begin ma = add(cx_r, tx_r); mb = dec_r; end
      6'd25: begin ma = add(cy_r, ty_r); mb = dec_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic is_div;
  assign is_div = (step == 6'd0) || (step == 6'd6) || (step == 6'd11) ||
                  (step == 6'd13) || (step == 6'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_time_r <= 31'd65536;
      max_speed_r   <= 31'h7FFFFFFF;
      vel_x_r       <= '0;
      vel_y_r       <= '0;
      dbusy_r       <= 1'b0;
      mphase_r      <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_fire && cfg_hit) begin
        if (cfg_idx == REG_SMOOTH_TIME) smooth_time_r <= cfg_wdata;
        else if (cfg_idx == REG_MAX_SPEED) max_speed_r <= cfg_wdata;
      end
      if (in_fire) begin
        cur_x_r <= satf((W+2)'(in_data.current_x));
        cur_y_r <= satf((W+2)'(in_data.current_y));
        tgt_x_r <= satf((W+2)'(in_data.target_x));
        tgt_y_r <= satf((W+2)'(in_data.target_y));
        dt_r    <= satf((W+2)'($signed({1'b0, in_data.delta_time})));
        st_r    <= (satf((W+2)'($signed({1'b0, smooth_time_r}))) < W'(StMin))
                   ? W'(StMin) : satf((W+2)'($signed({1'b0, smooth_time_r})));
        ms_r    <= satf((W+2)'($signed({1'b0, max_speed_r})));
        vx_r    <= vel_x_r;
        vy_r    <= vel_y_r;
        pos_r   <= '0;
        neg_r   <= '0;
        snap_r  <= 1'b0;
        clamp_r <= 1'b0;
      end
      if (cmd.start) begin
        if (is_div || (step == 6'd11 && 1'b0)) begin
          dbusy_r <= 1'b1;
          dsqrt_r <= 1'b0;
          dcnt_r  <= CW'(PW);
          dq_r    <= '0;
          drem_r  <= '0;
          case (step)
            6'd0: begin dn_r <= PW'(1) << (2*F+1); dd_r <= PW'(st_r); end
            6'd6: begin dn_r <= PW'(1) << (2*F); dd_r <= PW'(den_r); end
            6'd11: begin
              dsqrt_r <= 1'b1;
              dcnt_r  <= CW'(W + 1);
              dn_r    <= sq_r;
            end
            6'd13: begin dn_r <= lsq_r; dd_r <= len_r; end
            6'd15: begin dn_r <= lsq_r; dd_r <= len_r; end
            default: dd_r <= PW'(1);
          endcase
          if (!clamp_r && (step == 6'd11 || step == 6'd13 || step == 6'd15)) begin
            dbusy_r <= 1'b0;
            done    <= 1'b1;
          end
        end else begin
          mphase_r <= 1'b1;
        end
      end else if (mphase_r) begin
        mphase_r <= 1'b0;
        done     <= 1'b1;
        case (step)
          6'd1:  x_r <= mulq;
          6'd2:  xx_r <= mulq;
          6'd3:  xxx_r <= mulq;
          6'd4:  t_r <= mulq;
          6'd5:  den_r <= add(add(add(W'(OneQ), x_r), t_r), mulq);
          6'd7:  begin
            lim_r <= mulq;
            cx_r  <= sub(cur_x_r, tgt_x_r);
            cy_r  <= sub(cur_y_r, tgt_y_r);
          end
          6'd8:  sq_r <= PW'(mprod);
          6'd9:  sq_r <= sq_r + PW'(mprod);
          6'd10: begin
            lsq_r   <= PW'(mprod);
            clamp_r <= sq_r > PW'(mprod);
          end
          6'd12: lsq_r <= PW'(mprod);
          6'd14: lsq_r <= PW'(mprod);
          6'd16: t_r <= mulq;
          6'd17: tx_r <= mulq;
          6'd18: t_r <= mulq;
          6'd19: ty_r <= mulq;
          6'd20: t_r <= mulq;
          6'd21: vx_r <= mulq;
          6'd22: t_r <= mulq;
          6'd23: vy_r <= mulq;
          6'd24: ox_r <= add(sub(cur_x_r, cx_r), mulq);
          6'd25: oy_r <= add(sub(cur_y_r, cy_r), mulq);
          6'd26: begin
            if (mneg_r) neg_r <= neg_r + PW'(mprod);
            else pos_r <= pos_r + PW'(mprod);
          end
          6'd27: begin
            if (mneg_r) neg_r <= neg_r + PW'(mprod);
            else pos_r <= pos_r + PW'(mprod);
          end
          6'd28: snap_r <= pos_r > neg_r;
          default: ;
        endcase
      end else if (dbusy_r) begin
        if (dsqrt_r) begin
          if (dcnt_r == '0) begin
            dbusy_r <= 1'b0;
            done    <= 1'b1;
            len_r   <= (dq_r == '0) ? PW'(1) : dq_r;
          end else begin
            dn_r   <= dn_r << 2;
            dcnt_r <= dcnt_r - CW'(1);
            if (srem >= sroot) begin
              drem_r <= srem - sroot;
              dq_r   <= {dq_r[PW-2:0], 1'b1};
            end else begin
              drem_r <= srem;
              dq_r   <= {dq_r[PW-2:0], 1'b0};
            end
          end
        end else if (dcnt_r == '0) begin
          dbusy_r <= 1'b0;
          done    <= 1'b1;
          case (step)
            6'd0: omega_r <= smag(1'b0, dq_r);
            6'd6: dec_r <= smag(1'b0, dq_r);
            6'd13: cx_r <= smag(cx_r[W-1], dq_r);
            6'd15: cy_r <= smag(cy_r[W-1], dq_r);
            default: ;
          endcase
        end else begin
          dn_r   <= dn_r << 1;
          dcnt_r <= dcnt_r - CW'(1);
          if (!dtrial[PW]) begin
            drem_r <= dtrial[PW-1:0];
            dq_r   <= {dq_r[PW-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[PW-2:0], dn_r[PW-1]};
            dq_r   <= {dq_r[PW-2:0], 1'b0};
          end
        end
      end
      if (cmd.start && !is_div && (step >= 6'd29)) begin
        mphase_r <= 1'b0;
        done     <= 1'b1;
        if (step == 6'd29) begin
          if (snap_r) begin
            ox_r <= tgt_x_r;
            oy_r <= tgt_y_r;
            vx_r <= '0;
            vy_r <= '0;
          end
        end
        if (step == 6'd30) begin
          vel_x_r <= sat32w(vx_r);
          vel_y_r <= sat32w(vy_r);
        end
      end
      if (cmd.start && (step == 6'd12 || step == 6'd14) && !clamp_r) begin
        mphase_r <= 1'b0;
        done     <= 1'b1;
      end
    end
  end

  // Steps 13 and 15 divide the product that steps 12 and 14 keep in lsq_r.
  assign stat.done = done;

  assign res.out_x   = 32'(sat32w(ox_r));
  assign res.out_y   = 32'(sat32w(oy_r));
  assign res.speed_x = 32'(vel_x_r);
  assign res.speed_y = 32'(vel_y_r);
  assign res.snapped = snap_r;

  a_snap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && step == 6'd30 && snap_r) |=> (vel_x_r == '0 && vel_y_r == '0))
    else $error("snap kept velocity");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (dbusy_r && !dsqrt_r) |-> (dd_r != '0)) else $error("divide by zero");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(dbusy_r && mphase_r)) else $error("two units busy");
endmodule

// ===== hw/rtl/smooth_damp_2d_unit.sv =====
// ============================================================================
// smooth_damp_2d_unit: 2D critically damped smooth-damp step
// Top level joining the step sequencer and the fixed-point datapath.
// ============================================================================
// Usage: a request on in_* carries current position, target and time step.
// The block holds one request at a time; in_ready is high only while idle.
// Each request runs a fixed micro-step program on one shared multiplier,
// a one-bit-per-cycle divider and a two-bits-per-cycle square-root unit.
// When the offset is clamped, the program adds a square root, two products
// and two divisions that shorten the offset to its limit.
// The result holds on out_* until out_ready takes it; a stalled receiver
// keeps the block busy and in_ready low. Writes on cfg_* are always taken;
// index 0 is smooth time, index 1 is max speed, other indexes are ignored.
// Reset (rst_n low, synchronous) clears the stored velocity and restores
// smooth time 1.0 and max speed at full scale. No clearing pass is needed.
// ============================================================================
module smooth_damp_2d_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sd2_pkg::sd2_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sd2_pkg::sd2_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_index,
  input  logic [31:0]       cfg_data
);
  import sd2_pkg::*;

  sd2_cmd_t  cmd;
  sd2_stat_t stat;
  logic      busy, in_fire, out_fire, cfg_fire, cfg_hit;

  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index[31:1] == '0);

  sd2_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  sd2_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_data(in_data),
    .cfg_fire(cfg_fire), .cfg_idx(cfg_index[0:0]), .cfg_wdata(cfg_data[30:0]),
    .cfg_hit(cfg_hit), .cmd(cmd), .stat(stat),
    .res(out_data)
  );
endmodule
